>>> rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

	// request function codes
	localparam logic [2:0] FN_CLEAR  = 3'd0;
	localparam logic [2:0] FN_APPEND = 3'd1;
	localparam logic [2:0] FN_DELETE = 3'd2;
	localparam logic [2:0] FN_SEARCH = 3'd3;
	localparam logic [2:0] FN_INSERT = 3'd4;
	localparam logic [2:0] FN_READ   = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// per-cycle command broadcast to every list cell
	localparam logic [2:0] CELL_HOLD       = 3'd0;
	localparam logic [2:0] CELL_PUT        = 3'd1;
	localparam logic [2:0] CELL_OPEN       = 3'd2;
	localparam logic [2:0] CELL_CLOSE      = 3'd3;
	localparam logic [2:0] CELL_LOAD_MATCH = 3'd4;
	localparam logic [2:0] CELL_SCAN       = 3'd5;

	typedef struct packed {
		logic [2:0]         func;
		logic [3:0]         position;
		logic signed [31:0] value;
	} ple_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_index;
		logic signed [31:0] read_value;
		logic [4:0]         count;
	} ple_rsp_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} ple_cell_ctl_t;

endpackage

>>> rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: control, cell row and result queue.
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells, one entry per
// cell. Clear, append, delete, insert and read finish in the cycle of the transfer and their
// results are registered in the result queue; these run at one per cycle while the queue has
// room. Insert and delete shift each cell at or above the slot against its neighbour at once.
// Search compares all cells in the transfer cycle, then shifts the match flags one cell per
// cycle towards cell zero while an index counter follows, until the first match reaches cell
// zero or the last entry is scanned; an empty list answers not found. No request is taken
// meanwhile. A two-entry result queue lets a request be taken while a result waits.
// Entries need no clearing after reset; only positions below the count are ever read.
module positional_list_engine_unit import ple_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ple_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ple_rsp_t rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = ((CW > 4) ? CW : 4) + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic               state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      count_d;
	logic               accept;
	logic               q_full;
	logic               res_push;
	logic               start_scan;
	ple_rsp_t           res;
	ple_cell_ctl_t      ctl;
	logic [CW-1:0]      slot;
	logic [CMPW-1:0]    pos_w;
	logic [CMPW-1:0]    cnt_w;
	logic               list_full;
	logic               scan_last;
	logic signed [31:0] entry_w [CAPACITY];
	logic               match_w [CAPACITY];

	assign req_stall = (state_q == ST_SCAN) || q_full;
	assign accept    = req_valid && !req_stall;
	assign pos_w     = CMPW'(req.position);
	assign cnt_w     = CMPW'(count_q);
	assign list_full = (count_q == CW'(CAPACITY));
	assign scan_last = ((idx_q + CW'(1)) == count_q);

	// decode the request and drive the cell row
	always_comb begin
		ctl.op          = CELL_HOLD;
		ctl.value       = req.value;
		slot            = count_q;
		count_d         = count_q;
		res_push        = 1'b0;
		start_scan      = 1'b0;
		res.status      = ST_OK;
		res.found_index = 4'd0;
		res.read_value  = 32'sd0;
		if (state_q == ST_SCAN) begin
			ctl.op = CELL_SCAN;
			if (match_w[0]) begin
				res_push        = 1'b1;
				res.found_index = 4'(idx_q);
			end else if (scan_last) begin
				res_push   = 1'b1;
				res.status = ST_NOTFOUND;
			end
		end else if (accept) begin
			res_push = 1'b1;
			unique case (req.func)
				FN_CLEAR: begin
					count_d = '0;
				end
				FN_APPEND: begin
					if (list_full) begin
						res.status = ST_FULL;
					end else begin
						ctl.op  = CELL_PUT;
						count_d = count_q + CW'(1);
					end
				end
				FN_DELETE: begin
					if (pos_w >= cnt_w) begin
						res.status = ST_BADPOS;
					end else begin
						ctl.op  = CELL_CLOSE;
						slot    = pos_w[CW-1:0];
						count_d = count_q - CW'(1);
					end
				end
				FN_SEARCH: begin
					if (count_q == '0) begin
						res.status = ST_NOTFOUND;
					end else begin
						ctl.op     = CELL_LOAD_MATCH;
						res_push   = 1'b0;
						start_scan = 1'b1;
					end
				end
				FN_INSERT: begin
					if (pos_w > cnt_w) begin
						res.status = ST_BADPOS;
					end else if (list_full) begin
						res.status = ST_FULL;
					end else begin
						ctl.op  = CELL_OPEN;
						slot    = pos_w[CW-1:0];
						count_d = count_q + CW'(1);
					end
				end
				FN_READ: begin
					if (pos_w >= cnt_w) res.status = ST_BADPOS;
					else res.read_value = entry_w[pos_w[IW-1:0]];
				end
				default: begin
				end
			endcase
		end
		res.count = 5'(count_d);
	end

	// hold the count, advance the scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			count_q <= count_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start_scan) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (res_push) state_q <= ST_IDLE;
					else idx_q <= idx_q + CW'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// row of cells; neighbours feed each other
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		logic               right_match_w;
		if (k == 0) begin : g_first
			assign left_w = req.value;
		end else begin : g_mid_l
			assign left_w = entry_w[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_w       = entry_w[k];
			assign right_match_w = 1'b0;
		end else begin : g_mid_r
			assign right_w       = entry_w[k+1];
			assign right_match_w = match_w[k+1];
		end
		ple_cell #(
			.CW  (CW),
			.IDX (k)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.slot        (slot),
			.left        (left_w),
			.right       (right_w),
			.right_match (right_match_w),
			.entry       (entry_w[k]),
			.match       (match_w[k])
		);
	end

	ple_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (q_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list count beyond capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !q_full)
		else $error("result pushed into a full queue");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < count_q))
		else $error("scan index ran past the list");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without a request transfer");
`endif

endmodule

>>> rtl/ple_cell.sv
// One list cell: holds one entry and one match flag, trades with its neighbours.
module ple_cell import ple_pkg::*; #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  ple_cell_ctl_t      ctl,
	input  logic [CW-1:0]      slot,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic               right_match,
	output logic signed [31:0] entry,
	output logic               match
);

	logic signed [31:0] entry_q;
	logic               match_q;
	logic               here;
	logic               above;

	// locate this cell against the addressed slot
	assign here  = (slot == CW'(IDX));
	assign above = (slot < CW'(IDX));

	// update the stored entry: write, open a gap, or close one
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_PUT: begin
				if (here) entry_q <= ctl.value;
			end
			CELL_OPEN: begin
				if (here) entry_q <= ctl.value;
				else if (above) entry_q <= left;
			end
			CELL_CLOSE: begin
				if (here || above) entry_q <= right;
			end
			default: begin
			end
		endcase
	end

	// load the compare result, then pass it down towards cell zero
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_LOAD_MATCH: match_q <= (entry_q == ctl.value);
			CELL_SCAN:       match_q <= right_match;
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

>>> rtl/ple_outq.sv
// Two-entry result queue: output register plus skid register.
module ple_outq import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ple_rsp_t push_data,
	output logic     full,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ple_rsp_t rsp
);

	ple_rsp_t out_q;
	ple_rsp_t skid_q;
	logic     out_vld_q;
	logic     skid_vld_q;
	logic     out_free;
	logic     load_out;
	logic     load_skid;

	assign out_free  = !out_vld_q || !rsp_stall;
	assign load_out  = out_free && (skid_vld_q || push);
	assign load_skid = !out_free && push;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_vld_q  <= skid_vld_q || push;
				skid_vld_q <= 1'b0;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// move payloads; skid drains first to keep order
	always_ff @(posedge clk) begin
		if (load_out) out_q <= skid_vld_q ? skid_q : push_data;
		if (load_skid) skid_q <= push_data;
	end

	assign full      = skid_vld_q;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule
